### hw/rtl/grb_pkg.sv
package grb_pkg;

   // Pin and word geometry of the standard register map.
   localparam int PIN_COUNT   = 54;
   localparam int PinBits     = 54;
   localparam int WordBits    = 32;
   localparam int IndexBits   = 6;
   localparam int FselWords   = 6;
   localparam int FselAddrBits = 3;
   localparam int PinsPerFsel = 10;
   localparam int FselBits    = 3;
   localparam int PullBits    = 2;

   localparam logic [63:0] PinMask64 =
      (PIN_COUNT >= 64) ? {64{1'b1}} : ((64'd1 << PIN_COUNT) - 64'd1);

   // Word offsets.
   localparam logic [IndexBits-1:0] IDX_FSEL_LAST = 6'd5;
   localparam logic [IndexBits-1:0] IDX_SET0      = 6'd7;
   localparam logic [IndexBits-1:0] IDX_SET1      = 6'd8;
   localparam logic [IndexBits-1:0] IDX_CLR0      = 6'd10;
   localparam logic [IndexBits-1:0] IDX_CLR1      = 6'd11;
   localparam logic [IndexBits-1:0] IDX_LEV0      = 6'd13;
   localparam logic [IndexBits-1:0] IDX_LEV1      = 6'd14;
   localparam logic [IndexBits-1:0] IDX_PUD       = 6'd37;
   localparam logic [IndexBits-1:0] IDX_PUDCLK0   = 6'd38;
   localparam logic [IndexBits-1:0] IDX_PUDCLK1   = 6'd39;

   localparam logic                OP_WRITE    = 1'b1;
   localparam logic [FselBits-1:0] FSEL_OUTPUT = 3'd1;
   localparam logic [PullBits-1:0] PULL_DOWN   = 2'd1;
   localparam logic [PullBits-1:0] PULL_UP     = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic execute;
   } dp_cmd_type;

   // Places a data word on pin bank 0 or 1, limited to existing pins.
   function automatic logic [PinBits-1:0] bank_bits(logic [WordBits-1:0] word, logic bank);
      logic [63:0] v;
      v = {32'd0, word};
      if (bank) begin
         v = v << WordBits;
      end
      v = v & PinMask64;
      return v[PinBits-1:0];
   endfunction

   // Extracts the word of pin bank 0 or 1.
   function automatic logic [WordBits-1:0] bank_word(logic [PinBits-1:0] bits, logic bank);
      logic [63:0] v;
      v = {{(64-PinBits){1'b0}}, bits} & PinMask64;
      if (bank) begin
         v = v >> WordBits;
      end
      return v[WordBits-1:0];
   endfunction

endpackage

### hw/rtl/gpio_register_block.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    opcode, word_index, write_data, pin_inputs
// rsp       out        rsp_valid/rsp_ready    read_data, bad_address, drive and pull masks
//
// A transaction is executed at the edge where it is accepted; its result is
// offered from the next cycle.
// A new transaction is taken in the cycle its predecessor's result leaves,
// giving one transaction per cycle while rsp_ready stays high.
// Synchronous reset zeroes the configuration registers: all pins inputs, no pull.
// A stalled result holds; no new transaction enters until it is taken.
module gpio_register_block import grb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_opcode,
   input  logic [IndexBits-1:0] req_word_index,
   input  logic [WordBits-1:0]  req_write_data,
   input  logic [PinBits-1:0]   req_pin_inputs,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [WordBits-1:0]  rsp_read_data,
   output logic                 rsp_bad_address,
   output logic [PinBits-1:0]   rsp_drive_levels,
   output logic [PinBits-1:0]   rsp_drive_enable,
   output logic [PinBits-1:0]   rsp_pull_up_mask,
   output logic [PinBits-1:0]   rsp_pull_down_mask
);

   dp_cmd_type dp_cmd;

   grb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_cmd    (dp_cmd)
   );

   grb_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .dp_cmd             (dp_cmd),
      .req_opcode         (req_opcode),
      .req_word_index     (req_word_index),
      .req_write_data     (req_write_data),
      .req_pin_inputs     (req_pin_inputs),
      .rsp_read_data      (rsp_read_data),
      .rsp_bad_address    (rsp_bad_address),
      .rsp_drive_levels   (rsp_drive_levels),
      .rsp_drive_enable   (rsp_drive_enable),
      .rsp_pull_up_mask   (rsp_pull_up_mask),
      .rsp_pull_down_mask (rsp_pull_down_mask)
   );

endmodule

### hw/rtl/grb_ctrl.sv
module grb_ctrl import grb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type dp_cmd
);

   state_type state_ff;
   state_type state_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A new transaction may enter in the same cycle as the waiting result leaves.
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            req_ready = rsp_ready;
            if (rsp_ready && !req_valid) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      accept         = req_valid && req_ready;
      dp_cmd.execute = accept;
   end

endmodule

### hw/rtl/grb_datapath.sv
module grb_datapath import grb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           dp_cmd,
   input  logic                 req_opcode,
   input  logic [IndexBits-1:0] req_word_index,
   input  logic [WordBits-1:0]  req_write_data,
   input  logic [PinBits-1:0]   req_pin_inputs,
   output logic [WordBits-1:0]  rsp_read_data,
   output logic                 rsp_bad_address,
   output logic [PinBits-1:0]   rsp_drive_levels,
   output logic [PinBits-1:0]   rsp_drive_enable,
   output logic [PinBits-1:0]   rsp_pull_up_mask,
   output logic [PinBits-1:0]   rsp_pull_down_mask
);

   logic [WordBits-1:0] fsel_ff [FselWords];
   logic [WordBits-1:0] fsel_in [FselWords];
   logic [PinBits-1:0]  output_latch_ff;
   logic [PinBits-1:0]  output_latch_in;
   logic [PullBits-1:0] pull_control_ff;
   logic [PullBits-1:0] pull_control_in;
   logic [WordBits-1:0] pull_clock_ff [2];
   logic [WordBits-1:0] pull_clock_in [2];
   logic [PullBits-1:0] pull_state_ff [PinBits];
   logic [PullBits-1:0] pull_state_in [PinBits];
   logic [WordBits-1:0] read_data_ff;
   logic [WordBits-1:0] read_data_in;
   logic                bad_address_ff;
   logic                bad_address_in;

   logic                wr;
   logic                bank;
   logic [WordBits-1:0] rd;
   logic [PinBits-1:0]  hit;

   always_comb begin
      fsel_in         = fsel_ff;
      output_latch_in = output_latch_ff;
      pull_control_in = pull_control_ff;
      pull_clock_in   = pull_clock_ff;
      pull_state_in   = pull_state_ff;
      read_data_in    = read_data_ff;
      bad_address_in  = bad_address_ff;
      wr   = (req_opcode == OP_WRITE);
      rd   = '0;
      hit  = '0;
      bank = (req_word_index == IDX_SET1) || (req_word_index == IDX_CLR1) ||
             (req_word_index == IDX_LEV1) || (req_word_index == IDX_PUDCLK1);

      if (dp_cmd.execute) begin
         bad_address_in = 1'b0;
         case (req_word_index) inside
            [6'd0:IDX_FSEL_LAST]: begin
               if (wr) begin
                  fsel_in[req_word_index[FselAddrBits-1:0]] = req_write_data;
               end else begin
                  rd = fsel_ff[req_word_index[FselAddrBits-1:0]];
               end
            end
            IDX_SET0, IDX_SET1: begin
               if (wr) begin
                  output_latch_in = output_latch_ff | bank_bits(req_write_data, bank);
               end
            end
            IDX_CLR0, IDX_CLR1: begin
               if (wr) begin
                  output_latch_in = output_latch_ff & ~bank_bits(req_write_data, bank);
               end
            end
            IDX_LEV0, IDX_LEV1: begin
               if (!wr) begin
                  rd = bank_word(req_pin_inputs, bank);
               end
            end
            IDX_PUD: begin
               if (wr) begin
                  pull_control_in = req_write_data[PullBits-1:0];
               end else begin
                  rd = {{(WordBits-PullBits){1'b0}}, pull_control_ff};
               end
            end
            IDX_PUDCLK0, IDX_PUDCLK1: begin
               if (wr) begin
                  pull_clock_in[bank] = req_write_data;
                  hit = bank_bits(req_write_data, bank);
               end else begin
                  rd = pull_clock_ff[bank];
               end
            end
            default: begin
               bad_address_in = 1'b1;
            end
         endcase

         // Each clocked pin takes the pull code held before this transaction.
         for (int p = 0; p < PinBits; p++) begin
            if (hit[p]) begin
               pull_state_in[p] = pull_control_ff;
            end
         end

         output_latch_in = output_latch_in & PinMask64[PinBits-1:0];
         read_data_in    = wr ? '0 : rd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FselWords; i++) begin
            fsel_ff[i] <= '0;
         end
         output_latch_ff  <= '0;
         pull_control_ff  <= '0;
         pull_clock_ff[0] <= '0;
         pull_clock_ff[1] <= '0;
         for (int p = 0; p < PinBits; p++) begin
            pull_state_ff[p] <= '0;
         end
      end else begin
         fsel_ff         <= fsel_in;
         output_latch_ff <= output_latch_in;
         pull_control_ff <= pull_control_in;
         pull_clock_ff   <= pull_clock_in;
         pull_state_ff   <= pull_state_in;
      end
   end

   always_ff @(posedge clock) begin
      read_data_ff   <= read_data_in;
      bad_address_ff <= bad_address_in;
   end

   // Pin masks are decoded straight from the state, which only moves on a new transaction or reset.
   for (genvar p = 0; p < PinBits; p++) begin : g_pin
      localparam int FselWord  = p / PinsPerFsel;
      localparam int FselShift = (p % PinsPerFsel) * FselBits;
      if ((FselWord < FselWords) && (p < PIN_COUNT)) begin : g_fsel
         assign rsp_drive_enable[p] =
            (fsel_ff[FselWord][FselShift +: FselBits] == FSEL_OUTPUT);
      end else begin : g_nofsel
         assign rsp_drive_enable[p] = 1'b0;
      end
      assign rsp_pull_up_mask[p]   = (pull_state_ff[p] == PULL_UP);
      assign rsp_pull_down_mask[p] = (pull_state_ff[p] == PULL_DOWN);
   end

   assign rsp_read_data    = read_data_ff;
   assign rsp_bad_address  = bad_address_ff;
   assign rsp_drive_levels = output_latch_ff;

endmodule

### tb/gpio_access_checker.sv
module gpio_access_checker import grb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic                 req_opcode,
   input  logic [IndexBits-1:0] req_word_index,
   input  logic [WordBits-1:0]  req_write_data,
   input  logic [PinBits-1:0]   req_pin_inputs,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [WordBits-1:0]  rsp_read_data,
   input  logic                 rsp_bad_address,
   input  logic [PinBits-1:0]   rsp_drive_levels,
   input  logic [PinBits-1:0]   rsp_drive_enable,
   input  logic [PinBits-1:0]   rsp_pull_up_mask,
   input  logic [PinBits-1:0]   rsp_pull_down_mask,
   output int                   error_count,
   output int                   reports_waiting,
   output int                   reports_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [WordBits-1:0] read_data;
      logic                bad_address;
      logic [PinBits-1:0]  levels;
      logic [PinBits-1:0]  enables;
      logic [PinBits-1:0]  pull_ups;
      logic [PinBits-1:0]  pull_downs;
   } pin_report_type;

   // Shadow copy of the register file.
   logic [WordBits-1:0] fsel_words [FselWords];
   logic [PinBits-1:0]  out_latch;
   logic [PullBits-1:0] pud_code;
   logic [WordBits-1:0] pudclk_words [2];
   logic [PullBits-1:0] pin_pull [PIN_COUNT];

   pin_report_type awaited_reports [$];

   function automatic pin_report_type apply_bus_access(input logic wr,
                                                       input logic [IndexBits-1:0] idx,
                                                       input logic [WordBits-1:0] data,
                                                       input logic [PinBits-1:0] pins);
      pin_report_type r;
      logic [63:0] placed;
      logic        bank;
      r = '0;
      if (idx <= IDX_FSEL_LAST) begin
         if (wr == OP_WRITE) begin
            fsel_words[idx[FselAddrBits-1:0]] = data;
         end else begin
            r.read_data = fsel_words[idx[FselAddrBits-1:0]];
         end
      end else if (idx == IDX_SET0 || idx == IDX_SET1) begin
         placed = 64'(data) << ((idx == IDX_SET1) ? WordBits : 0);
         if (wr == OP_WRITE) begin
            out_latch = out_latch | placed[PinBits-1:0];
         end
      end else if (idx == IDX_CLR0 || idx == IDX_CLR1) begin
         placed = 64'(data) << ((idx == IDX_CLR1) ? WordBits : 0);
         if (wr == OP_WRITE) begin
            out_latch = out_latch & ~placed[PinBits-1:0];
         end
      end else if (idx == IDX_LEV0 || idx == IDX_LEV1) begin
         placed = 64'(pins) >> ((idx == IDX_LEV1) ? WordBits : 0);
         if (wr != OP_WRITE) begin
            r.read_data = placed[WordBits-1:0];
         end
      end else if (idx == IDX_PUD) begin
         if (wr == OP_WRITE) begin
            pud_code = data[PullBits-1:0];
         end else begin
            r.read_data = {{(WordBits-PullBits){1'b0}}, pud_code};
         end
      end else if (idx == IDX_PUDCLK0 || idx == IDX_PUDCLK1) begin
         bank = (idx == IDX_PUDCLK1);
         if (wr == OP_WRITE) begin
            pudclk_words[bank] = data;
            placed = 64'(data) << (bank ? WordBits : 0);
            // Only a 1 written now latches; a bit left high from before does not.
            for (int p = 0; p < PIN_COUNT; p++) begin
               if (placed[p]) begin
                  pin_pull[p] = pud_code;
               end
            end
         end else begin
            r.read_data = pudclk_words[bank];
         end
      end else begin
         r.bad_address = 1'b1;
      end

      r.levels = out_latch;
      for (int p = 0; p < PIN_COUNT; p++) begin
         r.enables[p] = (fsel_words[p / PinsPerFsel][(p % PinsPerFsel) * FselBits +: FselBits]
                         == FSEL_OUTPUT);
         r.pull_ups[p] = (pin_pull[p] == PULL_UP);
         r.pull_downs[p] = (pin_pull[p] == PULL_DOWN);
      end
      return r;
   endfunction

   task automatic check_field(input string field, input logic [63:0] want_v,
                              input logic [63:0] got_v);
      if (want_v !== got_v) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, field, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin : watch
      pin_report_type want;
      if (reset) begin
         foreach (fsel_words[i]) fsel_words[i] = '0;
         foreach (pudclk_words[i]) pudclk_words[i] = '0;
         foreach (pin_pull[i]) pin_pull[i] = '0;
         out_latch = '0;
         pud_code = '0;
         awaited_reports.delete();
         error_count = 0;
         reports_checked = 0;
      end else begin
         // The response side is handled first, so a response that arrives with
         // nothing outstanding is never matched against this edge's request.
         if (rsp_valid && rsp_ready) begin
            if (awaited_reports.size() == 0) begin
               error_count++;
               $display("%0t: response with no transaction outstanding, actual read_data %h",
                        $time, rsp_read_data);
            end else begin
               want = awaited_reports.pop_front();
               check_field("read_data", want.read_data, rsp_read_data);
               check_field("bad_address", want.bad_address, rsp_bad_address);
               check_field("drive_levels", want.levels, rsp_drive_levels);
               check_field("drive_enable", want.enables, rsp_drive_enable);
               check_field("pull_up_mask", want.pull_ups, rsp_pull_up_mask);
               check_field("pull_down_mask", want.pull_downs, rsp_pull_down_mask);
               reports_checked++;
            end
         end
         if (req_valid && req_ready) begin
            awaited_reports.push_back(apply_bus_access(req_opcode, req_word_index,
                                                       req_write_data, req_pin_inputs));
         end
      end
      reports_waiting = awaited_reports.size();
   end

endmodule

### tb/tb_gpio_register_block.sv
module tb_gpio_register_block;
   import grb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic                 OP_READ          = 1'b0;
   localparam logic [IndexBits-1:0] IDX_FSEL0        = 6'd0;
   localparam logic [IndexBits-1:0] IDX_FSEL1        = 6'd1;
   localparam logic [IndexBits-1:0] IDX_RESERVED     = 6'd6;
   localparam logic [IndexBits-1:0] IDX_EVENT_DETECT = 6'd16;
   localparam logic [IndexBits-1:0] IDX_TOP          = 6'd63;
   localparam int                   RSP_HOLD_CYCLES  = 120;
   localparam int                   TIMEOUT_NS       = 2_000_000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_opcode;
   logic [IndexBits-1:0] req_word_index;
   logic [WordBits-1:0]  req_write_data;
   logic [PinBits-1:0]   req_pin_inputs;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [WordBits-1:0]  rsp_read_data;
   logic                 rsp_bad_address;
   logic [PinBits-1:0]   rsp_drive_levels;
   logic [PinBits-1:0]   rsp_drive_enable;
   logic [PinBits-1:0]   rsp_pull_up_mask;
   logic [PinBits-1:0]   rsp_pull_down_mask;

   int error_count;
   int reports_waiting;
   int reports_checked;
   int accesses_sent;
   int writes_sent;
   int req_idle_pct;
   int rsp_idle_pct;
   logic rsp_hold_request;
   logic rsp_hold_done = 1'b0;

   gpio_register_block dut (.*);

   gpio_access_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Run stopped: the block stopped making progress.");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Response side: random back-pressure, plus one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (rsp_hold_request && !rsp_hold_done) begin
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES - 1) @(posedge clock);
            rsp_hold_done = 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   function automatic logic [PinBits-1:0] random_pins();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[PinBits-1:0];
   endfunction

   function automatic logic [WordBits-1:0] random_word();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         2: return 32'd1 << $urandom_range(WordBits - 1);
         default: return $urandom;
      endcase
   endfunction

   // Function-select data, often with a good share of pins set to output.
   function automatic logic [WordBits-1:0] random_fsel_word();
      logic [WordBits-1:0] w;
      w = $urandom;
      if ($urandom_range(1)) begin
         for (int f = 0; f < PinsPerFsel; f++) begin
            w[f * FselBits +: FselBits] = $urandom_range(1) ? FSEL_OUTPUT : 3'($urandom_range(7));
         end
      end
      return w;
   endfunction

   function automatic logic [IndexBits-1:0] mapped_index();
      logic [4:0] pick;
      pick = 5'($urandom_range(15));
      if (pick <= 5'(IDX_FSEL_LAST)) begin
         return IndexBits'(pick);
      end
      case (pick)
         6:  return IDX_SET0;
         7:  return IDX_SET1;
         8:  return IDX_CLR0;
         9:  return IDX_CLR1;
         10: return IDX_LEV0;
         11: return IDX_LEV1;
         12: return IDX_PUD;
         13: return IDX_PUDCLK0;
         default: return IDX_PUDCLK1;
      endcase
   endfunction

   task automatic send_access(input logic op, input logic [IndexBits-1:0] idx,
                              input logic [WordBits-1:0] data,
                              input logic [PinBits-1:0] pins);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_word_index <= idx;
      req_write_data <= data;
      req_pin_inputs <= pins;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      accesses_sent++;
      if (op == OP_WRITE) begin
         writes_sent++;
      end
   endtask

   task automatic random_access();
      logic [IndexBits-1:0] idx;
      logic                 op;
      int                   kind;
      kind = $urandom_range(99);
      if (kind < 15) begin
         // Pull programming as software does it: code, clock pulse, clock release.
         idx = $urandom_range(1) ? IDX_PUDCLK1 : IDX_PUDCLK0;
         send_access(OP_WRITE, IDX_PUD, random_word(), random_pins());
         send_access(OP_WRITE, idx, random_word(), random_pins());
         send_access(OP_WRITE, idx, '0, random_pins());
      end else if (kind < 27) begin
         send_access(1'($urandom_range(1)), IndexBits'($urandom_range(63)), random_word(),
                     random_pins());
      end else begin
         idx = mapped_index();
         op = 1'($urandom_range(1));
         if (op == OP_WRITE && idx <= IDX_FSEL_LAST) begin
            send_access(op, idx, random_fsel_word(), random_pins());
         end else begin
            send_access(op, idx, random_word(), random_pins());
         end
      end
   endtask

   task automatic run_random_phase(input int target, input int req_pct, input int rsp_pct);
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      while (accesses_sent < target) random_access();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_READ;
      req_word_index = '0;
      req_write_data = '0;
      req_pin_inputs = '0;
      rsp_hold_request = 1'b0;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      accesses_sent = 0;
      writes_sent = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed accesses covering each kind of register and the corner cases.
      send_access(OP_READ,  IDX_FSEL0,     '1,            random_pins());
      send_access(OP_WRITE, IDX_FSEL0,     32'h0924_9249, random_pins());
      send_access(OP_WRITE, IDX_FSEL_LAST, '1,            random_pins());
      send_access(OP_READ,  IDX_FSEL_LAST, '0,            random_pins());
      send_access(OP_WRITE, IDX_FSEL1,     32'h3FFF_FFFF, random_pins());
      send_access(OP_WRITE, IDX_SET0,      '1,            random_pins());
      send_access(OP_WRITE, IDX_SET1,      '1,            random_pins());
      send_access(OP_READ,  IDX_SET0,      '1,            random_pins());
      send_access(OP_WRITE, IDX_CLR1,      '1,            random_pins());
      send_access(OP_WRITE, IDX_CLR0,      32'h0000_FFFF, random_pins());
      send_access(OP_READ,  IDX_CLR1,      '0,            random_pins());
      send_access(OP_READ,  IDX_LEV0,      '1,            '1);
      send_access(OP_READ,  IDX_LEV1,      '0,            '1);
      send_access(OP_READ,  IDX_LEV1,      '0,            '0);
      send_access(OP_WRITE, IDX_LEV0,      '1,            '1);
      send_access(OP_WRITE, IDX_PUD,       32'hFFFF_FFFE, random_pins());
      send_access(OP_WRITE, IDX_PUDCLK0,   '1,            random_pins());
      send_access(OP_WRITE, IDX_PUDCLK1,   '1,            random_pins());
      send_access(OP_READ,  IDX_PUDCLK1,   '0,            random_pins());
      // The clock words are still high here, yet the new code must not latch.
      send_access(OP_WRITE, IDX_PUD,       32'd1,         random_pins());
      send_access(OP_READ,  IDX_PUD,       '1,            random_pins());
      send_access(OP_WRITE, IDX_PUDCLK1,   32'd1,         random_pins());
      send_access(OP_WRITE, IDX_PUD,       32'd3,         random_pins());
      send_access(OP_WRITE, IDX_PUDCLK0,   32'h8000_0001, random_pins());
      send_access(OP_READ,  IDX_RESERVED,  '1,            random_pins());
      send_access(OP_WRITE, IDX_TOP,       '1,            random_pins());
      send_access(OP_READ,  IDX_EVENT_DETECT, '0,         random_pins());

      run_random_phase(330, 34, 50);
      run_random_phase(630, 50, 34);

      // Long response hold-off with the request side pushing flat out.
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      rsp_hold_request = 1'b1;
      run_random_phase(670, 0, 0);
      run_random_phase(880, 0, 0);

      req_valid <= 1'b0;
      @(posedge clock);
      while (reports_waiting != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Sent %0d bus accesses (%0d writes) and checked %0d responses,",
               accesses_sent, writes_sent, reports_checked);
      $display("under mixed idling, no idling and a %0d-cycle response hold-off.",
               RSP_HOLD_CYCLES);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### gpio_register_block.f
hw/rtl/grb_pkg.sv
hw/rtl/grb_ctrl.sv
hw/rtl/grb_datapath.sv
hw/rtl/gpio_register_block.sv
tb/gpio_access_checker.sv
tb/tb_gpio_register_block.sv
